// File: src/udiv128_pkg.sv
// Shared types and constants for the 128-bit unsigned divider.
`default_nettype none

package udiv128_pkg;

   localparam int WordWidth  = 128;
   localparam int HalfWidth  = 64;
   localparam int StepCount  = WordWidth;
   localparam int CountWidth = $clog2(StepCount);

   localparam logic [CountWidth-1:0] LastStep = CountWidth'(StepCount - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_zero;
   } dp_status_type;

endpackage

`default_nettype wire

// File: src/udiv128_dp.sv
// Datapath of the 128-bit divider: partial remainder, dividend/quotient shifter, divisor.
`default_nettype none

module udiv128_dp (
   input  wire logic                              clock,
   input  wire udiv128_pkg::dp_cmd_type           cmd,
   output udiv128_pkg::dp_status_type             status,
   input  wire logic [udiv128_pkg::HalfWidth-1:0] dividend_lo,
   input  wire logic [udiv128_pkg::HalfWidth-1:0] dividend_hi,
   input  wire logic [udiv128_pkg::HalfWidth-1:0] divisor_lo,
   input  wire logic [udiv128_pkg::HalfWidth-1:0] divisor_hi,
   output logic      [udiv128_pkg::HalfWidth-1:0] quotient_lo,
   output logic      [udiv128_pkg::HalfWidth-1:0] quotient_hi,
   output logic      [udiv128_pkg::HalfWidth-1:0] remainder_lo,
   output logic      [udiv128_pkg::HalfWidth-1:0] remainder_hi,
   output logic                                   divide_by_zero
);

   localparam int W = udiv128_pkg::WordWidth;
   localparam int H = udiv128_pkg::HalfWidth;

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;   // dividend bits leave at the top, quotient bits enter below
   logic [W-1:0] den_ff, den_in;
   logic         dbz_ff, dbz_in;

   logic [W:0]   shifted;
   logic [W:0]   diff;
   logic [W-1:0] num;
   logic [W-1:0] den;

   assign num     = {dividend_hi, dividend_lo};
   assign den     = {divisor_hi, divisor_lo};
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      dbz_in = dbz_ff;
      if (cmd.load) begin
         den_in = den;
         rem_in = '0;
         if (den == '0) begin
            dbz_in = 1'b1;
            quo_in = '1;
            rem_in = num;
         end else begin
            dbz_in = 1'b0;
            quo_in = num;
         end
      end else if (cmd.step) begin
         // no borrow: subtract and set the quotient bit
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
         end else begin
            rem_in = shifted[W-1:0];
         end
         quo_in = {quo_ff[W-2:0], ~diff[W]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      dbz_ff <= dbz_in;
   end

   assign status.div_zero = dbz_ff;
   assign quotient_lo     = quo_ff[H-1:0];
   assign quotient_hi     = quo_ff[W-1:H];
   assign remainder_lo    = rem_ff[H-1:0];
   assign remainder_hi    = rem_ff[W-1:H];
   assign divide_by_zero  = dbz_ff;

endmodule

`default_nettype wire

// File: src/udiv128_ctrl.sv
// Controller of the 128-bit divider: sequencing and bit counter.
`default_nettype none

module udiv128_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire udiv128_pkg::dp_status_type   status,
   output udiv128_pkg::dp_cmd_type           cmd,
   output logic                              busy,
   output logic                              done
);

   udiv128_pkg::state_type state_ff, state_in;
   logic [udiv128_pkg::CountWidth-1:0] cnt_ff, cnt_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         udiv128_pkg::ST_IDLE: begin
            if (start) begin
               state_in = udiv128_pkg::ST_RUN;
            end
         end
         udiv128_pkg::ST_RUN: begin
            if (status.div_zero || cnt_ff == udiv128_pkg::LastStep) begin
               state_in = udiv128_pkg::ST_DONE;
            end
         end
         udiv128_pkg::ST_DONE: begin
            state_in = udiv128_pkg::ST_IDLE;
         end
         default: begin
            state_in = udiv128_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      busy     = 1'b1;
      done     = 1'b0;
      case (state_ff)
         udiv128_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         udiv128_pkg::ST_RUN: begin
            cmd.step = !status.div_zero;
         end
         udiv128_pkg::ST_DONE: begin
            done = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.step) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= udiv128_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: src/unsigned_128bit_divider.sv
// Top level of the 128-bit unsigned restoring divider.
//
//  channel   ports                               handshake
//  --------  ----------------------------------  ---------------------------------
//  request   req_dividend_*, req_divisor_*       taken when start && !busy
//  result    rsp_quotient_*, rsp_remainder_*,    one-cycle strobe rsp_valid
//            rsp_divide_by_zero
//
// A request runs through a load, 128 shift/compare/subtract iterations (one
// quotient bit per cycle through a single 129-bit subtractor) and a cycle with
// the result strobed. A zero divisor skips the iterations and goes from the run
// state to the strobe. busy is high from the cycle after acceptance until the
// strobe has gone by. Synchronous active-high reset clears the controller only.
// The receiver cannot stall: the result is shown for one cycle.
`default_nettype none

module unsigned_128bit_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [udiv128_pkg::HalfWidth-1:0] req_dividend_lo,
   input  wire logic [udiv128_pkg::HalfWidth-1:0] req_dividend_hi,
   input  wire logic [udiv128_pkg::HalfWidth-1:0] req_divisor_lo,
   input  wire logic [udiv128_pkg::HalfWidth-1:0] req_divisor_hi,
   output logic                                   rsp_valid,
   output logic      [udiv128_pkg::HalfWidth-1:0] rsp_quotient_lo,
   output logic      [udiv128_pkg::HalfWidth-1:0] rsp_quotient_hi,
   output logic      [udiv128_pkg::HalfWidth-1:0] rsp_remainder_lo,
   output logic      [udiv128_pkg::HalfWidth-1:0] rsp_remainder_hi,
   output logic                                   rsp_divide_by_zero
);

   udiv128_pkg::dp_cmd_type    cmd;
   udiv128_pkg::dp_status_type status;

   // sequencing: load, 128 steps, strobe
   udiv128_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_valid)
   );

   // result registers stay stable while the strobe is up
   udiv128_dp u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .dividend_lo    (req_dividend_lo),
      .dividend_hi    (req_dividend_hi),
      .divisor_lo     (req_divisor_lo),
      .divisor_hi     (req_divisor_hi),
      .quotient_lo    (rsp_quotient_lo),
      .quotient_hi    (rsp_quotient_hi),
      .remainder_lo   (rsp_remainder_lo),
      .remainder_hi   (rsp_remainder_hi),
      .divide_by_zero (rsp_divide_by_zero)
   );

endmodule

`default_nettype wire
